FILE: rtl/nnr_pkg.sv
// ----------------------------------------------------------------------------
// nnr_pkg
// Shared types and constants for the nearest-neighbor image resize core:
// beat layouts of both channels, size register set, command and register codes.
// ----------------------------------------------------------------------------
package nnr_pkg;

    // Default sizing of the frame store and pixel width
    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;
    localparam int PIXEL_BITS_DEF = 32;

    // Fixed field widths
    localparam int CFG_BITS   = 9;
    localparam int FIELD_BITS = 32;
    localparam int PADDR_BITS = 4;
    localparam int PDATA_BITS = 32;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
    localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
    localparam logic [1:0] REG_DST_WIDTH  = 2'd2;
    localparam logic [1:0] REG_DST_HEIGHT = 2'd3;

    // Input commands
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EMIT = 1'b1;

    typedef struct packed {
        logic                  cmd;
        logic [FIELD_BITS-1:0] pixel_in;
    } in_beat_t;

    typedef struct packed {
        logic [FIELD_BITS-1:0] pixel_out;
        logic                  frame_last;
    } out_beat_t;

    typedef struct packed {
        logic [CFG_BITS-1:0] src_width;
        logic [CFG_BITS-1:0] src_height;
        logic [CFG_BITS-1:0] dst_width;
        logic [CFG_BITS-1:0] dst_height;
    } size_cfg_t;

endpackage

FILE: rtl/nnr_div.sv
// ----------------------------------------------------------------------------
// nnr_div
// Restoring divider, one quotient bit per cycle. Starts on a pulse and holds
// the quotient once busy drops.
// ----------------------------------------------------------------------------
module nnr_div #(
    parameter int NUM_BITS = 18,
    parameter int DEN_BITS = 10
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [NUM_BITS-1:0] num,
    input  logic [DEN_BITS-1:0] den,
    output logic                busy,
    output logic [NUM_BITS-1:0] quo
);

    localparam int CNT_BITS = (NUM_BITS > 1) ? $clog2(NUM_BITS) : 1;

    logic                busy_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic [NUM_BITS-1:0] num_reg;
    logic [DEN_BITS-1:0] den_reg;
    logic [DEN_BITS-1:0] rem_reg;
    logic [NUM_BITS-1:0] quo_reg;

    logic [DEN_BITS:0]   rem_sh;
    logic                ge;
    logic [DEN_BITS:0]   diff;
    logic [DEN_BITS-1:0] rem_next;

    // trial subtract of the shifted remainder
    assign rem_sh   = {rem_reg, num_reg[NUM_BITS-1]};
    assign ge       = (rem_sh >= {1'b0, den_reg});
    assign diff     = rem_sh - {1'b0, den_reg};
    assign rem_next = ge ? diff[DEN_BITS-1:0] : rem_sh[DEN_BITS-1:0];

    // control: iteration count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_BITS'(NUM_BITS - 1);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[NUM_BITS-2:0], 1'b0};
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[NUM_BITS-2:0], ge};
        end
    end

    assign busy = busy_reg;
    assign quo  = quo_reg;

endmodule

FILE: rtl/nnr_fifo.sv
// ----------------------------------------------------------------------------
// nnr_fifo
// Two-entry queue between the front end and the frame store back end.
// ----------------------------------------------------------------------------
module nnr_fifo #(
    parameter int WIDTH = 52
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);

    logic [WIDTH-1:0] slot_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       cnt_reg;

    logic             do_push;
    logic             do_pop;

    assign do_push = push && (cnt_reg != 2'd2);
    assign do_pop  = pop && (cnt_reg != 2'd0);

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data = slot_reg[rd_ptr_reg];
    assign full     = (cnt_reg == 2'd2);
    assign empty    = (cnt_reg == 2'd0);

endmodule

FILE: rtl/nnr_front.sv
// ----------------------------------------------------------------------------
// nnr_front
// Front end: takes input beats, tracks load and destination positions, maps
// each destination pixel to its source pixel and queues store operations.
// ----------------------------------------------------------------------------
module nnr_front #(
    parameter int MAX_WIDTH  = nnr_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = nnr_pkg::MAX_HEIGHT_DEF,
    parameter int ADDR_BITS  = 16,
    parameter int ENTRY_BITS = 2 + 16 + nnr_pkg::FIELD_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  nnr_pkg::in_beat_t     in_data,
    output logic                  in_stall,
    input  nnr_pkg::size_cfg_t    cfg,
    input  logic                  q_full,
    output logic                  q_push,
    output logic [ENTRY_BITS-1:0] q_entry
);

    localparam int SWB = $clog2(MAX_WIDTH + 1);
    localparam int SHB = $clog2(MAX_HEIGHT + 1);
    localparam int XB  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YB  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int NXB = XB + 1 + SWB;
    localparam int NYB = YB + 1 + SHB;
    localparam int FB  = SWB + SHB;
    localparam int PB  = YB + SWB;

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_ADDR} state_t;

    state_t                state_reg;
    logic [ADDR_BITS-1:0]  load_pos_reg;
    logic [XB-1:0]         col_reg;
    logic [YB-1:0]         row_reg;
    logic                  last_reg;

    logic [SWB-1:0]        sw;
    logic [SWB-1:0]        dw;
    logic [SHB-1:0]        sh;
    logic [SHB-1:0]        dh;

    logic                  accept;
    logic                  is_emit;

    logic [FB-1:0]         frame;
    logic [ADDR_BITS-1:0]  pos;
    logic [FB-1:0]         pos_inc;
    logic [ADDR_BITS-1:0]  load_pos_next;

    logic [XB-1:0]         x_eff;
    logic [YB-1:0]         y_eff;
    logic [XB:0]           x_inc;
    logic [YB:0]           y_inc;
    logic                  x_end;
    logic                  y_end;
    logic [NXB-1:0]        num_x;
    logic [NYB-1:0]        num_y;
    logic [NXB-1:0]        quo_x;
    logic [NYB-1:0]        quo_y;
    logic                  busy_x;
    logic                  busy_y;

    logic [SWB-1:0]        sw_m1;
    logic [SHB-1:0]        sh_m1;
    logic [NXB-1:0]        sx_wide;
    logic [NYB-1:0]        sy_wide;
    logic [PB-1:0]         addr_sum;

    // size registers: zero reads as one, oversize as the store maximum
    always_comb
    begin
        sw = (cfg.src_width == '0) ? SWB'(1) :
             (cfg.src_width > MAX_WIDTH) ? SWB'(MAX_WIDTH) : SWB'(cfg.src_width);
        dw = (cfg.dst_width == '0) ? SWB'(1) :
             (cfg.dst_width > MAX_WIDTH) ? SWB'(MAX_WIDTH) : SWB'(cfg.dst_width);
        sh = (cfg.src_height == '0) ? SHB'(1) :
             (cfg.src_height > MAX_HEIGHT) ? SHB'(MAX_HEIGHT) : SHB'(cfg.src_height);
        dh = (cfg.dst_height == '0) ? SHB'(1) :
             (cfg.dst_height > MAX_HEIGHT) ? SHB'(MAX_HEIGHT) : SHB'(cfg.dst_height);
    end

    assign in_stall = (state_reg != S_IDLE) || q_full;
    assign accept   = in_valid && !in_stall;
    assign is_emit  = (in_data.cmd == nnr_pkg::CMD_EMIT);

    // load position: restart when outside the current frame
    always_comb
    begin
        frame         = {{SHB{1'b0}}, sw} * {{SWB{1'b0}}, sh};
        pos           = (FB'(load_pos_reg) >= frame) ? '0 : load_pos_reg;
        pos_inc       = FB'(pos) + FB'(1);
        load_pos_next = (pos_inc >= frame) ? '0 : pos_inc[ADDR_BITS-1:0];
    end

    // destination position, wrap and source numerators
    always_comb
    begin
        x_eff = (SWB'(col_reg) >= dw) ? '0 : col_reg;
        y_eff = (SHB'(row_reg) >= dh) ? '0 : row_reg;
        x_inc = (XB + 1)'(x_eff) + (XB + 1)'(1);
        y_inc = (YB + 1)'(y_eff) + (YB + 1)'(1);
        x_end = (x_inc >= (XB + 1)'(dw));
        y_end = (y_inc >= (YB + 1)'(dh));
        num_x = NXB'({x_eff, 1'b1}) * NXB'(sw);
        num_y = NYB'({y_eff, 1'b1}) * NYB'(sh);
    end

    nnr_div #(
        .NUM_BITS (NXB),
        .DEN_BITS (SWB + 1)
    ) u_div_x (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept && is_emit),
        .num   (num_x),
        .den   ({dw, 1'b0}),
        .busy  (busy_x),
        .quo   (quo_x)
    );

    nnr_div #(
        .NUM_BITS (NYB),
        .DEN_BITS (SHB + 1)
    ) u_div_y (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept && is_emit),
        .num   (num_y),
        .den   ({dh, 1'b0}),
        .busy  (busy_y),
        .quo   (quo_y)
    );

    // clamp source coordinates and form the store address
    always_comb
    begin
        sw_m1    = sw - SWB'(1);
        sh_m1    = sh - SHB'(1);
        sx_wide  = (quo_x > NXB'(sw_m1)) ? NXB'(sw_m1) : quo_x;
        sy_wide  = (quo_y > NYB'(sh_m1)) ? NYB'(sh_m1) : quo_y;
        addr_sum = PB'(sy_wide[YB-1:0]) * PB'(sw) + PB'(sx_wide[XB-1:0]);
    end

    // queue entry: {read, last, address, pixel}
    always_comb
    begin
        q_push  = 1'b0;
        q_entry = {1'b0, 1'b0, pos, in_data.pixel_in};
        unique case (state_reg)
            S_IDLE:
            begin
                q_push = accept && !is_emit;
            end
            S_ADDR:
            begin
                q_push  = !q_full;
                q_entry = {1'b1, last_reg, addr_sum[ADDR_BITS-1:0],
                           {nnr_pkg::FIELD_BITS{1'b0}}};
            end
            default:
            begin
                q_push = 1'b0;
            end
        endcase
    end

    // sequencer and position registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            load_pos_reg <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
            last_reg     <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept && !is_emit)
                    begin
                        load_pos_reg <= load_pos_next;
                    end
                    else if (accept)
                    begin
                        last_reg  <= x_end && y_end;
                        col_reg   <= x_end ? '0 : x_inc[XB-1:0];
                        row_reg   <= !x_end ? y_eff : (y_end ? '0 : y_inc[YB-1:0]);
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (!busy_x && !busy_y)
                    begin
                        state_reg <= S_ADDR;
                    end
                end
                S_ADDR:
                begin
                    if (!q_full)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: rtl/nnr_back.sv
// ----------------------------------------------------------------------------
// nnr_back
// Back end: owns the frame store, performs queued writes and reads, and holds
// the output beat until the receiver takes it.
// ----------------------------------------------------------------------------
module nnr_back #(
    parameter int DEPTH      = 65536,
    parameter int ADDR_BITS  = 16,
    parameter int PIXEL_BITS = nnr_pkg::PIXEL_BITS_DEF,
    parameter int ENTRY_BITS = 2 + 16 + nnr_pkg::FIELD_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_empty,
    input  logic [ENTRY_BITS-1:0] q_entry,
    output logic                  q_pop,
    output logic                  out_valid,
    input  logic                  out_stall,
    output nnr_pkg::out_beat_t    out_data
);

    localparam int FB = nnr_pkg::FIELD_BITS;

    logic [PIXEL_BITS-1:0] store [DEPTH];
    logic [PIXEL_BITS-1:0] rd_q_reg;
    logic                  last_q_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;

    logic                  is_read;
    logic                  last;
    logic [ADDR_BITS-1:0]  addr;
    logic [FB-1:0]         pixel;
    logic [PIXEL_BITS-1:0] din;
    logic [FB-1:0]         dout;
    logic                  wr_en;
    logic                  rd_en;

    // entry fields
    assign is_read = q_entry[ENTRY_BITS-1];
    assign last    = q_entry[ENTRY_BITS-2];
    assign addr    = q_entry[FB +: ADDR_BITS];
    assign pixel   = q_entry[FB-1:0];

    // a read goes ahead only when the output register is free or draining
    assign q_pop = !q_empty && (!is_read || !out_valid_reg || !out_stall);
    assign wr_en = q_pop && !is_read;
    assign rd_en = q_pop && is_read;

    // pixel width adaptation
    generate
        if (PIXEL_BITS > FB)
        begin : g_wide
            assign din  = {{(PIXEL_BITS - FB){1'b0}}, pixel};
            assign dout = rd_q_reg[FB-1:0];
        end
        else if (PIXEL_BITS == FB)
        begin : g_same
            assign din  = pixel;
            assign dout = rd_q_reg;
        end
        else
        begin : g_narrow
            assign din  = pixel[PIXEL_BITS-1:0];
            assign dout = {{(FB - PIXEL_BITS){1'b0}}, rd_q_reg};
        end
    endgenerate

    // frame store, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store[addr] <= din;
        end
        if (rd_en)
        begin
            rd_q_reg   <= store[addr];
            last_q_reg <= last;
        end
    end

    // output beat valid
    assign out_valid_next = rd_en || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid           = out_valid_reg;
    assign out_data.pixel_out  = dout;
    assign out_data.frame_last = last_q_reg;

endmodule

FILE: rtl/nearest_neighbor_image_resize_core.sv
// ----------------------------------------------------------------------------
// nearest_neighbor_image_resize_core
// Nearest-neighbor image scaler with an on-chip frame store.
//
// Input channel (in_valid/in_stall/in_data): a beat with cmd LOAD writes the
// next source pixel in raster order; a beat with cmd EMIT requests the next
// destination pixel. Output channel (out_valid/out_stall/out_data) carries one
// beat per EMIT, frame_last set on the final pixel of the destination frame.
// Sizes are set over the APB port (src/dst width and height); the user must
// write them only while idle, as the block does not enforce it.
// Throughput: a LOAD beat is taken every cycle while the queue has room and
// no EMIT is in progress. An EMIT beat holds the input while the bit-serial
// source coordinate dividers run (one quotient bit per cycle) and until its
// read enters the queue; the back end then reads the store into out_data.
// Reset clears positions and sets all sizes to 1; the frame store is not
// cleared, so pixels must be loaded before they are read.
// When the receiver stalls, the output beat holds; up to two queued
// operations wait behind it, then in_stall rises.
// ----------------------------------------------------------------------------
module nearest_neighbor_image_resize_core #(
    parameter int MAX_WIDTH  = nnr_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = nnr_pkg::MAX_HEIGHT_DEF,
    parameter int PIXEL_BITS = nnr_pkg::PIXEL_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // input beats
    input  logic                             in_valid,
    output logic                             in_stall,
    input  nnr_pkg::in_beat_t                in_data,
    // output beats
    output logic                             out_valid,
    input  logic                             out_stall,
    output nnr_pkg::out_beat_t               out_data,
    // register port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [nnr_pkg::PADDR_BITS-1:0]   paddr,
    input  logic [nnr_pkg::PDATA_BITS-1:0]   pwdata,
    output logic [nnr_pkg::PDATA_BITS-1:0]   prdata,
    output logic                             pready
);

    localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ENTRY_BITS = 2 + ADDR_BITS + nnr_pkg::FIELD_BITS;
    localparam int CB         = nnr_pkg::CFG_BITS;

    nnr_pkg::size_cfg_t    cfg_reg;
    logic [CB-1:0]         rd_val;

    logic                  q_push;
    logic [ENTRY_BITS-1:0] q_push_data;
    logic                  q_pop;
    logic [ENTRY_BITS-1:0] q_pop_data;
    logic                  q_full;
    logic                  q_empty;

    // size registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.src_width  <= CB'(1);
            cfg_reg.src_height <= CB'(1);
            cfg_reg.dst_width  <= CB'(1);
            cfg_reg.dst_height <= CB'(1);
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (paddr[3:2])
                nnr_pkg::REG_SRC_WIDTH:  cfg_reg.src_width  <= pwdata[CB-1:0];
                nnr_pkg::REG_SRC_HEIGHT: cfg_reg.src_height <= pwdata[CB-1:0];
                nnr_pkg::REG_DST_WIDTH:  cfg_reg.dst_width  <= pwdata[CB-1:0];
                nnr_pkg::REG_DST_HEIGHT: cfg_reg.dst_height <= pwdata[CB-1:0];
                default:                 cfg_reg            <= cfg_reg;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (paddr[3:2])
            nnr_pkg::REG_SRC_WIDTH:  rd_val = cfg_reg.src_width;
            nnr_pkg::REG_SRC_HEIGHT: rd_val = cfg_reg.src_height;
            nnr_pkg::REG_DST_WIDTH:  rd_val = cfg_reg.dst_width;
            nnr_pkg::REG_DST_HEIGHT: rd_val = cfg_reg.dst_height;
            default:                 rd_val = '0;
        endcase
    end

    assign prdata = {{(nnr_pkg::PDATA_BITS - CB){1'b0}}, rd_val};
    assign pready = 1'b1;

    nnr_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .ADDR_BITS  (ADDR_BITS),
        .ENTRY_BITS (ENTRY_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_data  (in_data),
        .in_stall (in_stall),
        .cfg      (cfg_reg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (q_push_data)
    );

    nnr_fifo #(
        .WIDTH (ENTRY_BITS)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    nnr_back #(
        .DEPTH      (DEPTH),
        .ADDR_BITS  (ADDR_BITS),
        .PIXEL_BITS (PIXEL_BITS),
        .ENTRY_BITS (ENTRY_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_entry   (q_pop_data),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

FILE: rtl/nnr_checker.sv
// ----------------------------------------------------------------------------
// nnr_checker
// Port-level checks for the resize core: emit/result accounting, emit
// sequencing and output hold under stall.
// ----------------------------------------------------------------------------
module nnr_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_stall,
    input  nnr_pkg::in_beat_t                in_data,
    input  logic                             out_valid,
    input  logic                             out_stall,
    input  nnr_pkg::out_beat_t               out_data
);

    logic       emit_beat;
    logic       out_beat;
    logic [2:0] pend_reg;

    assign emit_beat = in_valid && !in_stall && (in_data.cmd == nnr_pkg::CMD_EMIT);
    assign out_beat  = out_valid && !out_stall;

    // emits accepted but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 3'd0;
        end
        else if (emit_beat && !out_beat)
        begin
            pend_reg <= pend_reg + 3'd1;
        end
        else if (out_beat && !emit_beat)
        begin
            pend_reg <= pend_reg - 3'd1;
        end
    end

    // no result without an outstanding emit
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pend_reg != 3'd0))
        else $error("result beat with no outstanding emit");

    // front, queue and output register bound the outstanding emits
    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= 3'd4)
        else $error("more outstanding emits than the pipeline can hold");

    // an emit occupies the coordinate dividers, so the next beat waits
    a_emit_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        emit_beat |=> in_stall)
        else $error("input taken right after an emit");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output beat dropped under stall");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_data))
        else $error("output payload changed under stall");

endmodule

bind nearest_neighbor_image_resize_core nnr_checker u_nnr_checker (.*);
